// File: hdl/deq_pkg.sv
// shared constants, codes and types for the bounded deque
package deq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd4;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  // per-cell update command
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_IN_LEFT,
    CMD_WRITE_AT_COUNT,
    CMD_SHIFT_IN_RIGHT,
    CMD_CLOSE_AFTER_MATCH
  } cell_cmd_t;

  typedef struct packed {
    logic                     cmp_en;
    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         count;
  } cell_ctrl_t;

endpackage

// File: hdl/deq_if.sv
// request and result channel interfaces

interface deq_in_if;
  logic                             valid;
  logic                             ready;
  logic [deq_pkg::REQ_W-1:0]        req_type;
  logic signed [deq_pkg::DATA_W-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

interface deq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [deq_pkg::DATA_W-1:0] out_value;
  logic [deq_pkg::STAT_W-1:0]        status;
  logic [deq_pkg::COUNT_W-1:0]       entry_count;

  modport source (output valid, out_value, status, entry_count, input ready);
  modport sink   (input valid, out_value, status, entry_count, output ready);
endinterface

// File: hdl/deq_cell.sv
// one storage cell of the deque: holds an entry and its match flag
module deq_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [deq_pkg::IDX_W-1:0]         cell_idx,
  input  deq_pkg::cell_ctrl_t               ctrl,
  input  logic signed [deq_pkg::DATA_W-1:0] left_data,
  input  logic signed [deq_pkg::DATA_W-1:0] right_data,
  input  logic                              seen_in,
  output logic signed [deq_pkg::DATA_W-1:0] data,
  output logic signed [deq_pkg::DATA_W-1:0] last_data,
  output logic                              seen_out
);
  import deq_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     match_r;
  logic [CNT_W-1:0]         pos;

  assign pos      = CNT_W'(cell_idx);
  assign seen_out = seen_in | match_r;
  assign data     = data_r;
  // only the tail cell offers its entry for a pop from the back
  assign last_data = ((pos + CNT_W'(1)) == ctrl.count) ? data_r : '0;

  always_comb begin
    unique case (ctrl.cmd)
      CMD_HOLD:              data_nxt = data_r;
      CMD_SHIFT_IN_LEFT:     data_nxt = left_data;
      CMD_WRITE_AT_COUNT:    data_nxt = (pos == ctrl.count) ? ctrl.value : data_r;
      CMD_SHIFT_IN_RIGHT:    data_nxt = right_data;
      CMD_CLOSE_AFTER_MATCH: data_nxt = seen_out ? right_data : data_r;
      default:               data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      match_r <= (data_r == ctrl.value) && (pos < ctrl.count);
    end
  end

endmodule

// File: hdl/deq_cell_row.sv
// row of deque cells, front at cell 0, with the first-match chain
module deq_cell_row (
  input  logic                              clk,
  input  logic                              rst_n,
  input  deq_pkg::cell_ctrl_t               ctrl,
  output logic signed [deq_pkg::DATA_W-1:0] front_data,
  output logic signed [deq_pkg::DATA_W-1:0] back_data,
  output logic                              found
);
  import deq_pkg::*;

  logic signed [DATA_W-1:0] data    [CAPACITY];
  logic signed [DATA_W-1:0] last_d  [CAPACITY];
  logic [CAPACITY:0]        seen;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    // a push at the front enters at cell 0
    if (i == 0) begin : g_head
      assign left_d = ctrl.value;
    end else begin : g_body
      assign left_d = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = data[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .seen_in    (seen[i]),
      .data       (data[i]),
      .last_data  (last_d[i]),
      .seen_out   (seen[i+1])
    );
  end

  assign front_data = data[0];
  assign found      = seen[CAPACITY];

  always_comb begin
    back_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_data = back_data | last_d[i];
    end
  end

endmodule

// File: hdl/bounded_deque_with_value_removal_top.sv
// top level of the bounded deque with value removal
// In the cycle a request is accepted every cell compares its entry against the
// request value, and in the next cycle the cell row shifts or writes where the
// request needs it and the result is loaded into the output register. A new
// request is taken while the previous result waits, as long as that result is
// taken in the same cycle, but never while one is still executing. The
// first-match flag ripples from the front cell to the back one, so the length of
// that chain sets the clock limit for larger capacities.
module bounded_deque_with_value_removal_top (
  input  logic     clk,
  input  logic     rst_n,
  deq_in_if.sink   in_ch,
  deq_out_if.source out_ch
);
  import deq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                     state_r, state_nxt;
  logic [REQ_W-1:0]         kind_r;
  logic signed [DATA_W-1:0] value_r;
  logic [CNT_W-1:0]         count_r, count_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic [STAT_W-1:0]        out_status_r;
  logic [CNT_W-1:0]         out_count_r;

  logic                     in_fire;
  logic                     full, empty;
  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] front_data, back_data;
  logic                     found;
  cell_cmd_t                cmd;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] result;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  always_comb begin
    cmd       = CMD_HOLD;
    status    = STAT_OK;
    result    = '0;
    count_nxt = count_r;
    if (state_r == S_EXEC) begin
      unique case (kind_r)
        REQ_PUSH_FRONT: begin
          if (full) begin
            status = STAT_FULL;
          end else begin
            cmd       = CMD_SHIFT_IN_LEFT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_PUSH_BACK: begin
          if (full) begin
            status = STAT_FULL;
          end else begin
            cmd       = CMD_WRITE_AT_COUNT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            status = STAT_EMPTY;
          end else begin
            cmd       = CMD_SHIFT_IN_RIGHT;
            result    = front_data;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        REQ_POP_BACK: begin
          if (empty) begin
            status = STAT_EMPTY;
          end else begin
            result    = back_data;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        REQ_REMOVE: begin
          if (empty) begin
            status = STAT_EMPTY;
          end else if (found) begin
            cmd       = CMD_CLOSE_AFTER_MATCH;
            count_nxt = count_r - CNT_W'(1);
          end else begin
            status = STAT_NOT_FOUND;
          end
        end
        default: begin
          // unknown kinds change nothing
          status = STAT_OK;
        end
      endcase
    end
  end

  // compare uses the live request value, the update the captured one
  always_comb begin
    ctrl.cmp_en = in_fire;
    ctrl.cmd    = cmd;
    ctrl.value  = (state_r == S_IDLE) ? in_ch.value : value_r;
    ctrl.count  = count_r;
  end

  deq_cell_row u_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .front_data (front_data),
    .back_data  (back_data),
    .found      (found)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= in_ch.req_type;
      value_r <= in_ch.value;
    end
    if (state_r == S_EXEC) begin
      out_value_r  <= result;
      out_status_r <= status;
      out_count_r  <= count_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_value   = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = COUNT_W'(out_count_r);

endmodule

// File: hdl/deq_checker.sv
// port-level checks for the bounded deque, bound to the top level
module deq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [deq_pkg::STAT_W-1:0]  out_status,
  input logic [deq_pkg::COUNT_W-1:0] out_count
);
  import deq_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one item at a time: no second accept right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("item accepted while previous one in flight");

  // every accepted item yields a result after its execute state
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##2 out_valid)
    else $error("no result after accepted item");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> out_count == COUNT_W'(CAPACITY))
    else $error("full status without full count");

endmodule

bind bounded_deque_with_value_removal_top deq_checker u_deq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_count  (out_ch.entry_count)
);
